// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL.
// Depends on nothing; compiled out when NO_ASSERTIONS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- rtl/core/pfav_pkg.sv -----
// Package for the page frame allocator: widths, opcodes, request types.
// No dependencies.
package pfav_pkg;

    localparam int NUM_FRAMES        = 16;
    localparam int FRAME_W           = 4;
    localparam int PAGES             = 16;
    localparam int PAGE_W            = 4;
    localparam int CNT_W             = 5;
    localparam int PROC_W            = 2;
    localparam int DEF_NUM_PROCESSES = 4;

    localparam logic OP_FAULT   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [PROC_W-1:0] process;
        logic [PAGE_W-1:0] page;
        logic [CNT_W-1:0]  page_count;
        logic [FRAME_W-1:0] random_frame;
    } t_req;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               victim_used;
        logic [CNT_W-1:0]   released_count;
        logic               stack_overflow;
    } t_rsp;

    typedef struct packed {
        logic rd;
        logic clr;
        logic wr;
    } t_pt_cmd;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_cmd;

endpackage

// ----- rtl/core/pfav_ifs.sv -----
// Valid/ready channel interfaces for requests and results.
// Depends on pfav_pkg.
interface pfav_req_if import pfav_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface pfav_rsp_if import pfav_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/core/pfav_fstack.sv -----
// LIFO of free physical frames with fill count.
// Depends on pfav_pkg.
module pfav_fstack import pfav_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_stk_cmd           i_cmd,
    input  logic [FRAME_W-1:0] i_push_frame,
    output logic [FRAME_W-1:0] o_top_frame,
    output logic               o_empty,
    output logic               o_full
);

    logic [FRAME_W-1:0] r_stack [NUM_FRAMES];
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   top_idx;

    assign top_idx     = r_count - CNT_W'(1);
    assign o_top_frame = r_stack[top_idx[FRAME_W-1:0]];
    assign o_empty     = (r_count == '0);
    assign o_full      = (r_count == CNT_W'(NUM_FRAMES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_FRAMES; k++) begin
                r_stack[k] <= FRAME_W'(k);
            end
            r_count <= CNT_W'(NUM_FRAMES);
        end else if (i_cmd.push && !o_full) begin
            r_stack[r_count[FRAME_W-1:0]] <= i_push_frame;
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.pop && !o_empty) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

endmodule

// ----- rtl/core/pfav_ptab.sv -----
// Page table: frame memory with registered read plus per-entry valid flops.
// Depends on pfav_pkg.
module pfav_ptab import pfav_pkg::*; #(
    parameter int NUM_PROCESSES = DEF_NUM_PROCESSES
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  t_pt_cmd                                  i_cmd,
    input  logic [$clog2(NUM_PROCESSES*PAGES)-1:0]   i_rd_addr,
    input  logic [$clog2(NUM_PROCESSES*PAGES)-1:0]   i_wr_addr,
    input  logic [FRAME_W-1:0]                       i_wr_frame,
    output logic [FRAME_W-1:0]                       o_rd_frame,
    output logic                                     o_rd_valid
);

    localparam int DEPTH = NUM_PROCESSES * PAGES;

    logic [FRAME_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]   r_valid;
    logic [FRAME_W-1:0] r_rd_frame;
    logic               r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_wr_addr] <= i_wr_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_frame <= r_mem[i_rd_addr];
        end
    end

    // valid bit is sampled before the clear of the same entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_cmd.rd) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
            if (i_cmd.rd && i_cmd.clr) begin
                r_valid[i_rd_addr] <= 1'b0;
            end
            if (i_cmd.wr) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_frame = r_rd_frame;
    assign o_rd_valid = r_rd_valid;

endmodule

// ----- rtl/core/page_frame_allocator_victim.sv -----
// Page frame allocator, top level: sequencer, free stack, page table.
// After accept: a fault with a free frame pops it (S_POP); a release walks page_count pages
// (clamped to 16, S_WALK); a fault with an empty stack scans the table, then probes frames.
// One request in flight: the next request is taken only once the sequencer is back in S_IDLE.
// A finished result waits in the output register; a stalled o_rsp holds the sequencer.
// Sync active-low reset: stack holds frames 0..15 (15 on top), all pages invalid.
`include "assert_macros.svh"

module page_frame_allocator_victim import pfav_pkg::*; #(
    parameter int NUM_PROCESSES = DEF_NUM_PROCESSES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pfav_req_if.sink   i_req,
    pfav_rsp_if.source o_rsp
);

    localparam int DEPTH  = NUM_PROCESSES * PAGES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PIDX_W = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_POP   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    function automatic logic [PIDX_W-1:0] proc_mod(input logic [PROC_W-1:0] p);
        logic [4:0] v;
        v = 5'(p);
        for (int k = 0; k < 3; k++) begin
            if (v >= 5'(NUM_PROCESSES)) begin
                v = v - 5'(NUM_PROCESSES);
            end
        end
        return PIDX_W'(v);
    endfunction

    function automatic logic [FRAME_W-1:0] frame_inc(input logic [FRAME_W-1:0] f);
        return (f == FRAME_W'(NUM_FRAMES - 1)) ? '0 : f + FRAME_W'(1);
    endfunction

    logic [2:0]           r_state, n_state;
    logic                 r_op, n_op;
    logic [PIDX_W-1:0]    r_pidx, n_pidx;
    logic [PAGE_W-1:0]    r_page, n_page;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic                 r_pend, n_pend;
    logic [NUM_FRAMES-1:0] r_mask, n_mask;
    logic [FRAME_W-1:0]   r_f, n_f;
    logic [CNT_W-1:0]     r_pass, n_pass;
    logic [FRAME_W-1:0]   r_frame, n_frame;
    logic                 r_victim, n_victim;
    logic [CNT_W-1:0]     r_released, n_released;
    logic                 r_ovf, n_ovf;
    t_rsp                 r_out, n_out;
    logic                 r_out_valid, n_out_valid;

    t_pt_cmd              pt_cmd;
    logic [ADDR_W-1:0]    pt_rd_addr;
    logic [ADDR_W-1:0]    pt_wr_addr;
    logic [FRAME_W-1:0]   pt_wr_frame;
    logic [FRAME_W-1:0]   pt_rd_frame;
    logic                 pt_rd_valid;

    t_stk_cmd             stk_cmd;
    logic [FRAME_W-1:0]   stk_top;
    logic                 stk_empty;
    logic                 stk_full;

    logic                 hit;
    logic [CNT_W-1:0]     pass_n;
    logic [FRAME_W-1:0]   f_final;

    pfav_ptab #(
        .NUM_PROCESSES(NUM_PROCESSES)
    ) u_ptab (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (pt_cmd),
        .i_rd_addr  (pt_rd_addr),
        .i_wr_addr  (pt_wr_addr),
        .i_wr_frame (pt_wr_frame),
        .o_rd_frame (pt_rd_frame),
        .o_rd_valid (pt_rd_valid)
    );

    pfav_fstack u_fstack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (stk_cmd),
        .i_push_frame (pt_rd_frame),
        .o_top_frame  (stk_top),
        .o_empty      (stk_empty),
        .o_full       (stk_full)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    assign pt_rd_addr = ADDR_W'({r_pidx, r_idx[PAGE_W-1:0]});
    assign pt_wr_addr = ADDR_W'({r_pidx, r_page});
    assign hit        = r_mask[r_f];
    assign pass_n     = r_pass + CNT_W'(1);
    assign f_final    = hit ? frame_inc(r_f) : r_f;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_pidx      = r_pidx;
        n_page      = r_page;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_mask      = r_mask;
        n_f         = r_f;
        n_pass      = r_pass;
        n_frame     = r_frame;
        n_victim    = r_victim;
        n_released  = r_released;
        n_ovf       = r_ovf;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        pt_cmd      = '0;
        pt_wr_frame = stk_top;
        stk_cmd     = '0;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op       = i_req.data.operation;
                    n_pidx     = proc_mod(i_req.data.process);
                    n_page     = i_req.data.page;
                    n_cnt      = (i_req.data.page_count > CNT_W'(PAGES)) ?
                                 CNT_W'(PAGES) : i_req.data.page_count;
                    n_f        = i_req.data.random_frame;
                    n_idx      = '0;
                    n_pend     = 1'b0;
                    n_mask     = '0;
                    n_pass     = '0;
                    n_frame    = '0;
                    n_victim   = 1'b0;
                    n_released = '0;
                    n_ovf      = 1'b0;
                    if (i_req.data.operation == OP_RELEASE) begin
                        n_state = S_WALK;
                    end else if (stk_empty) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_POP;
                    end
                end
            end
            S_POP: begin
                stk_cmd.pop = 1'b1;
                pt_cmd.wr   = 1'b1;
                pt_wr_frame = stk_top;
                n_frame     = stk_top;
                n_state     = S_DONE;
            end
            S_SCAN: begin
                // build mask of frames this process maps
                if (r_idx < CNT_W'(PAGES)) begin
                    pt_cmd.rd = 1'b1;
                    n_idx     = r_idx + CNT_W'(1);
                end
                n_pend = (r_idx < CNT_W'(PAGES));
                if (r_pend && pt_rd_valid) begin
                    n_mask[pt_rd_frame] = 1'b1;
                end
                if (r_idx == CNT_W'(PAGES)) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                n_pass = pass_n;
                if (hit) begin
                    n_f = frame_inc(r_f);
                end
                if (!hit || (pass_n > CNT_W'(NUM_FRAMES))) begin
                    pt_cmd.wr   = 1'b1;
                    pt_wr_frame = f_final;
                    n_frame     = f_final;
                    n_victim    = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_WALK: begin
                if (r_idx < r_cnt) begin
                    pt_cmd.rd  = 1'b1;
                    pt_cmd.clr = 1'b1;
                    n_idx      = r_idx + CNT_W'(1);
                end
                n_pend = (r_idx < r_cnt);
                if (r_pend && pt_rd_valid) begin
                    if (!stk_full) begin
                        stk_cmd.push = 1'b1;
                        n_released   = r_released + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                if (r_idx >= r_cnt) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out.frame          = (r_op == OP_FAULT) ? r_frame : '0;
                    n_out.victim_used    = r_victim;
                    n_out.released_count = r_released;
                    n_out.stack_overflow = r_ovf;
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_pidx     <= n_pidx;
        r_page     <= n_page;
        r_cnt      <= n_cnt;
        r_idx      <= n_idx;
        r_mask     <= n_mask;
        r_f        <= n_f;
        r_pass     <= n_pass;
        r_frame    <= n_frame;
        r_victim   <= n_victim;
        r_released <= n_released;
        r_ovf      <= n_ovf;
        r_out      <= n_out;
    end

    `ASSERT_PROP(a_probe_only_empty, i_clk, i_rst_n, (r_state == S_PROBE) |-> stk_empty)
    `ASSERT_PROP(a_pop_has_frame, i_clk, i_rst_n, (r_state == S_POP) |-> !stk_empty)
    `ASSERT_NEVER(a_pass_bound, i_clk, i_rst_n, (r_state == S_PROBE) && (r_pass > CNT_W'(NUM_FRAMES)))
    `ASSERT_PROP(a_release_bound, i_clk, i_rst_n, (r_state == S_WALK) |-> (r_released <= r_idx))

endmodule
